FILE: design/spq_pkg.sv
`default_nettype none
package spq_pkg;

  localparam int unsigned NUM_PRIO = 6;
  localparam int unsigned PRIO_W   = 3;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 3'd5;

  typedef enum logic [1:0] {
    OUT_INSERTED = 2'd0,
    OUT_POPPED   = 2'd1,
    OUT_EMPTY    = 2'd2,
    OUT_FULL     = 2'd3
  } outcome_e;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_POP    = 1'b1
  } mode_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_e;

endpackage
`default_nettype wire

FILE: design/spq_in_if.sv
`default_nettype none
interface spq_in_if #(
  parameter int unsigned TAG_BITS = 16
);
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [TAG_BITS-1:0] task_tag;
  logic [PRIO_W-1:0]   task_priority;

  modport source (output valid, mode, task_tag, task_priority, input ready);
  modport sink   (input valid, mode, task_tag, task_priority, output ready);
endinterface
`default_nettype wire

FILE: design/spq_out_if.sv
`default_nettype none
interface spq_out_if #(
  parameter int unsigned TAG_BITS = 16,
  parameter int unsigned OCC_W    = 5
);
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  outcome_e            outcome;
  logic [TAG_BITS-1:0] popped_tag;
  logic [PRIO_W-1:0]   popped_priority;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, outcome, popped_tag, popped_priority, occupancy,
                  input ready);
  modport sink   (input valid, outcome, popped_tag, popped_priority, occupancy,
                  output ready);
endinterface
`default_nettype wire

FILE: design/spq_ram.sv
`default_nettype none
module spq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 96,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/stable_priority_task_queue_top.sv
`default_nettype none
// Insert, pop on empty and insert on full: one transaction accepted per cycle
//   while the output is free, result registered and shown in the cycle after
//   acceptance. Pop of a stored task: registered tag RAM read, then result load
//   once the output is free; no new transaction is accepted until that load.
// Reset (async, active low) empties the queue at once; no clearing pass is
//   needed since only slots between a head and a tail pointer are ever read.
module stable_priority_task_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;

  // One ring buffer per priority level inside a shared tag RAM. The address
  // is {priority, slot}; arrival order within a level is the ring order, so
  // the head of the best non-empty level is the stable queue head.
  localparam int unsigned OCC_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int unsigned ADDR_W   = PRIO_W + PTR_W;
  localparam int unsigned RAM_DEPTH = NUM_PRIO << PTR_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

  state_e state_q, state_d;

  logic [OCC_W-1:0] count_q, count_d;
  logic [OCC_W-1:0] lvl_cnt_q [NUM_PRIO];
  logic [OCC_W-1:0] lvl_cnt_d [NUM_PRIO];
  logic [PTR_W-1:0] head_q [NUM_PRIO];
  logic [PTR_W-1:0] head_d [NUM_PRIO];
  logic [PTR_W-1:0] tail_q [NUM_PRIO];
  logic [PTR_W-1:0] tail_d [NUM_PRIO];

  // Result register.
  logic                out_valid_q, out_valid_d;
  outcome_e            out_outcome_q, out_outcome_d;
  logic [TAG_BITS-1:0] out_tag_q, out_tag_d;
  logic [PRIO_W-1:0]   out_prio_q, out_prio_d;
  logic [OCC_W-1:0]    out_occ_q, out_occ_d;

  logic [PRIO_W-1:0] pop_prio_q, pop_prio_d;

  logic              accept;
  logic              is_pop;
  logic              out_free;
  logic              out_load;
  logic              empty;
  logic              full;
  logic [PRIO_W-1:0] ins_prio;
  logic [PRIO_W-1:0] best_prio;
  logic [PTR_W-1:0]  ins_slot;
  logic [PTR_W-1:0]  pop_slot;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [TAG_BITS-1:0] ram_rdata;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept = in_i.valid && in_i.ready;
  assign is_pop = (in_i.mode == MODE_POP);
  assign empty = (count_q == '0);
  assign full  = (count_q == OCC_FULL);

  // Saturate out-of-range priorities to the lowest level.
  assign ins_prio = (in_i.task_priority > PRIO_MAX) ? PRIO_MAX : in_i.task_priority;

  // Best non-empty level: scan from the lowest priority up so level 0 wins.
  always_comb begin
    best_prio = '0;
    for (int p = NUM_PRIO - 1; p >= 0; p--) begin
      if (lvl_cnt_q[p] != '0) begin
        best_prio = PRIO_W'(p);
      end
    end
  end

  assign ins_slot = tail_q[ins_prio];
  assign pop_slot = head_q[best_prio];

  assign ram_we    = accept && !is_pop && !full;
  assign ram_waddr = {ins_prio, ins_slot};
  assign ram_re    = accept && is_pop && !empty;
  assign ram_raddr = {best_prio, pop_slot};

  spq_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.task_tag),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (ram_re) begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Pointer and count bookkeeping; updated at acceptance.
  always_comb begin
    count_d    = count_q;
    pop_prio_d = pop_prio_q;
    for (int p = 0; p < NUM_PRIO; p++) begin
      lvl_cnt_d[p] = lvl_cnt_q[p];
      head_d[p]    = head_q[p];
      tail_d[p]    = tail_q[p];
    end
    if (ram_we) begin
      count_d             = count_q + OCC_W'(1);
      lvl_cnt_d[ins_prio] = lvl_cnt_q[ins_prio] + OCC_W'(1);
      tail_d[ins_prio]    = (ins_slot == PTR_LAST) ? '0 : ins_slot + PTR_W'(1);
    end
    if (ram_re) begin
      count_d              = count_q - OCC_W'(1);
      lvl_cnt_d[best_prio] = lvl_cnt_q[best_prio] - OCC_W'(1);
      head_d[best_prio]    = (pop_slot == PTR_LAST) ? '0 : pop_slot + PTR_W'(1);
      pop_prio_d           = best_prio;
    end
  end

  // Outputs: load the result register for immediate outcomes and once the
  // popped tag is back from the RAM.
  always_comb begin
    out_load      = 1'b0;
    out_outcome_d = out_outcome_q;
    out_tag_d     = out_tag_q;
    out_prio_d    = out_prio_q;
    out_occ_d     = out_occ_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !ram_re) begin
          out_load   = 1'b1;
          out_tag_d  = '0;
          out_prio_d = '0;
          out_occ_d  = count_d;
          if (is_pop) begin
            out_outcome_d = OUT_EMPTY;
          end else if (full) begin
            out_outcome_d = OUT_FULL;
          end else begin
            out_outcome_d = OUT_INSERTED;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_outcome_d = OUT_POPPED;
          out_tag_d     = ram_rdata;
          out_prio_d    = pop_prio_q;
          out_occ_d     = count_q;
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < NUM_PRIO; p++) begin
        lvl_cnt_q[p] <= '0;
        head_q[p]    <= '0;
        tail_q[p]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      for (int p = 0; p < NUM_PRIO; p++) begin
        lvl_cnt_q[p] <= lvl_cnt_d[p];
        head_q[p]    <= head_d[p];
        tail_q[p]    <= tail_d[p];
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    pop_prio_q    <= pop_prio_d;
    out_outcome_q <= out_outcome_d;
    out_tag_q     <= out_tag_d;
    out_prio_q    <= out_prio_d;
    out_occ_q     <= out_occ_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.outcome         = out_outcome_q;
  assign out_o.popped_tag      = out_tag_q;
  assign out_o.popped_priority = out_prio_q;
  assign out_o.occupancy       = out_occ_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OCC_FULL)
    else $error("queue count exceeds depth");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP && out_free) |=> (out_valid_q && out_outcome_q == OUT_POPPED))
    else $error("pop read did not produce a popped result");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (count_q == $past(count_q) + OCC_W'(1)))
    else $error("insert did not advance the count");

  a_best_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (lvl_cnt_q[best_prio] != '0))
    else $error("pop selected an empty priority level");

  a_prio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_prio_q <= PRIO_MAX))
    else $error("result priority out of range");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_stable_priority_task_queue_top.sv
`timescale 1ns / 100ps
module tb_stable_priority_task_queue_top;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH    = 16;
  localparam int unsigned TAG_BITS       = 16;
  localparam int unsigned OCC_W          = 5;
  localparam int unsigned DIRECTED_ROWS  = 25;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned PRESSURE_ITEMS = 125;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // One result as the block should show it.
  typedef struct packed {
    outcome_e            outcome;
    logic [TAG_BITS-1:0] tag;
    logic [PRIO_W-1:0]   prio;
    logic [OCC_W-1:0]    occupancy;
  } queue_result_t;

  // One row of the directed table; the golden result is typed in only where it
  // is obvious, otherwise the row is checked against the queue model.
  typedef struct {
    mode_e               mode;
    logic [TAG_BITS-1:0] tag;
    logic [PRIO_W-1:0]   prio;
    bit                  has_golden;
    queue_result_t       golden;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  #(.TAG_BITS(TAG_BITS))                task_in ();
  spq_out_if #(.TAG_BITS(TAG_BITS), .OCC_W(OCC_W)) result_out ();

  stable_priority_task_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (task_in),
    .out_o (result_out)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Queue model: a sorted copy of the stored tasks, kept in step with every
  // accepted transaction on the input side.
  // ---------------------------------------------------------------------------
  logic [TAG_BITS-1:0] held_tag  [QUEUE_DEPTH];
  logic [PRIO_W-1:0]   held_prio [QUEUE_DEPTH];
  int unsigned         held_count;

  function automatic queue_result_t predict_queue_step(mode_e m, logic [TAG_BITS-1:0] tag,
                                                       logic [PRIO_W-1:0] prio);
    queue_result_t r;
    logic [PRIO_W-1:0] p;
    int unsigned slot;
    int unsigned k;
    r.outcome = OUT_INSERTED;
    r.tag     = '0;
    r.prio    = '0;
    if (m == MODE_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.outcome = OUT_FULL;
      end else begin
        // Clamp priorities 6 and 7 to the lowest one.
        p = (prio > PRIO_MAX) ? PRIO_MAX : prio;
        // Place behind every entry of equal or better priority: keeps FIFO order.
        slot = 0;
        while (slot < held_count && held_prio[slot] <= p) slot++;
        for (k = held_count; k > slot; k--) begin
          held_tag[k]  = held_tag[k-1];
          held_prio[k] = held_prio[k-1];
        end
        held_tag[slot]  = tag;
        held_prio[slot] = p;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.outcome = OUT_EMPTY;
      end else begin
        r.outcome = OUT_POPPED;
        r.tag     = held_tag[0];
        r.prio    = held_prio[0];
        for (k = 1; k < held_count; k++) begin
          held_tag[k-1]  = held_tag[k];
          held_prio[k-1] = held_prio[k];
        end
        held_count--;
      end
    end
    r.occupancy = held_count[OCC_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: results are checked first at each edge, then the transaction
  // accepted at the same edge adds its expectation to the back of the queue.
  // ---------------------------------------------------------------------------
  queue_result_t pending_results[$];
  bit            row_golden_en;
  queue_result_t row_golden;

  int unsigned mismatch_count;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned outcome_seen[4];
  int unsigned peak_occupancy;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %0s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  logic in_fire;
  logic out_fire;
  assign in_fire  = task_in.valid && task_in.ready;
  assign out_fire = result_out.valid && result_out.ready;

  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t pred;
    if (rst_n) begin
      if (out_fire) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(result_out.outcome), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (result_out.outcome !== want.outcome)
            report_mismatch("outcome", 32'(result_out.outcome), 32'(want.outcome));
          if (result_out.popped_tag !== want.tag)
            report_mismatch("popped_tag", 32'(result_out.popped_tag), 32'(want.tag));
          if (result_out.popped_priority !== want.prio)
            report_mismatch("popped_priority", 32'(result_out.popped_priority),
                            32'(want.prio));
          if (result_out.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(result_out.occupancy), 32'(want.occupancy));
        end
      end
      if (in_fire) begin
        items_accepted++;
        pred = predict_queue_step(mode_e'(task_in.mode), task_in.task_tag,
                                  task_in.task_priority);
        outcome_seen[pred.outcome]++;
        if (32'(pred.occupancy) > peak_occupancy) peak_occupancy = 32'(pred.occupancy);
        // Typed-in rows check against their own golden value.
        pending_results.push_back(row_golden_en ? row_golden : pred);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no transaction moves on either side for too long.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if (in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still pending", $time,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls at the falling edge, overridden by a long hold-off
  // that fills the block and stalls its input.
  // ---------------------------------------------------------------------------
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;
  bit          hold_active;

  always @(negedge clk) begin
    if (hold_active) begin
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count the hold-off in clock cycles; switch it on and off at rising edges so
  // the receiver sees a settled value at the falling edge.
  always begin
    wait (hold_request);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active  = 1'b0;
    hold_request = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after its
  // transaction is accepted. Drop valid only for an idle gap, so it is never
  // lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_item(mode_e m, logic [TAG_BITS-1:0] tag, logic [PRIO_W-1:0] prio,
                           bit has_golden, queue_result_t golden);
    while ($urandom_range(99) < send_idle_pct) begin
      task_in.valid <= 1'b0;
      @(negedge clk);
    end
    task_in.valid         <= 1'b1;
    task_in.mode          <= m;
    task_in.task_tag      <= tag;
    task_in.task_priority <= prio;
    row_golden_en         <= has_golden;
    row_golden            <= golden;
    do @(posedge clk); while (!task_in.ready);
    @(negedge clk);
  endtask

  // Random traffic in bursts: alternate filling and draining every 48 items so
  // the queue swings between empty and full. Tags favor the extremes now and then.
  task automatic random_traffic(int unsigned count, bit fill_only);
    int unsigned n;
    int unsigned insert_pct;
    logic [TAG_BITS-1:0] tag;
    mode_e m;
    for (n = 0; n < count; n++) begin
      if (fill_only) insert_pct = 90;
      else insert_pct = ((n / 48) % 2 == 0) ? 70 : 30;
      m = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_POP;
      case ($urandom_range(7))
        0: tag = '0;
        1: tag = '1;
        default: tag = TAG_BITS'($urandom);
      endcase
      send_item(m, tag, PRIO_W'($urandom_range(7)), 1'b0, queue_result_t'('0));
    end
  endtask

  stim_row_t directed_rows[DIRECTED_ROWS];

  initial begin
    int unsigned i;
    // Directed table: pop on empty, extremes of tag and priority, clamped
    // priorities, equal-priority ties, fill to full, insert on full, pops.
    directed_rows[0]  = '{MODE_POP,    16'h0000, 3'd0, 1'b1, '{OUT_EMPTY,    16'h0, 3'd0, 5'd0}};
    directed_rows[1]  = '{MODE_INSERT, 16'hFFFF, 3'd5, 1'b1, '{OUT_INSERTED, 16'h0, 3'd0, 5'd1}};
    directed_rows[2]  = '{MODE_INSERT, 16'h0000, 3'd0, 1'b1, '{OUT_INSERTED, 16'h0, 3'd0, 5'd2}};
    directed_rows[3]  = '{MODE_INSERT, 16'h1111, 3'd7, 1'b0, queue_result_t'('0)};
    directed_rows[4]  = '{MODE_INSERT, 16'h2222, 3'd6, 1'b0, queue_result_t'('0)};
    directed_rows[5]  = '{MODE_INSERT, 16'h3333, 3'd5, 1'b0, queue_result_t'('0)};
    directed_rows[6]  = '{MODE_INSERT, 16'h4444, 3'd0, 1'b0, queue_result_t'('0)};
    directed_rows[7]  = '{MODE_INSERT, 16'h5555, 3'd1, 1'b0, queue_result_t'('0)};
    directed_rows[8]  = '{MODE_INSERT, 16'h6666, 3'd2, 1'b0, queue_result_t'('0)};
    directed_rows[9]  = '{MODE_INSERT, 16'h7777, 3'd3, 1'b0, queue_result_t'('0)};
    directed_rows[10] = '{MODE_INSERT, 16'h8888, 3'd4, 1'b0, queue_result_t'('0)};
    directed_rows[11] = '{MODE_INSERT, 16'hAAAA, 3'd2, 1'b0, queue_result_t'('0)};
    directed_rows[12] = '{MODE_INSERT, 16'h5A5A, 3'd1, 1'b0, queue_result_t'('0)};
    directed_rows[13] = '{MODE_INSERT, 16'hA5A5, 3'd4, 1'b0, queue_result_t'('0)};
    directed_rows[14] = '{MODE_INSERT, 16'h0001, 3'd3, 1'b0, queue_result_t'('0)};
    directed_rows[15] = '{MODE_INSERT, 16'h8000, 3'd0, 1'b0, queue_result_t'('0)};
    directed_rows[16] = '{MODE_INSERT, 16'h7FFF, 3'd7, 1'b0, queue_result_t'('0)};
    directed_rows[17] = '{MODE_INSERT, 16'hBEEF, 3'd0, 1'b1, '{OUT_FULL,     16'h0, 3'd0, 5'd16}};
    directed_rows[18] = '{MODE_POP,    16'hFFFF, 3'd7, 1'b1, '{OUT_POPPED,   16'h0, 3'd0, 5'd15}};
    for (i = 19; i < DIRECTED_ROWS; i++)
      directed_rows[i] = '{MODE_POP, 16'(i * 16'h0F0F), 3'(i), 1'b0, queue_result_t'('0)};

    // Hold every input at a known value, then reset once.
    held_count            = 0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    hold_request          = 1'b0;
    hold_active           = 1'b0;
    row_golden_en         = 1'b0;
    row_golden            = '0;
    task_in.valid         = 1'b0;
    task_in.mode          = MODE_INSERT;
    task_in.task_tag      = '0;
    task_in.task_priority = '0;
    result_out.ready      = 1'b0;
    rst_n                 = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table with no idling on either side.
    for (i = 0; i < DIRECTED_ROWS; i++)
      send_item(directed_rows[i].mode, directed_rows[i].tag, directed_rows[i].prio,
                directed_rows[i].has_golden, directed_rows[i].golden);

    // Random phases: no idling, sender idle, receiver stalling, both.
    random_traffic(PHASE_ITEMS, 1'b0);
    send_idle_pct = 54;
    random_traffic(PHASE_ITEMS, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 54;
    random_traffic(PHASE_ITEMS, 1'b0);
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    random_traffic(PHASE_ITEMS, 1'b0);

    // Back-pressure: hold the receiver off while inserts keep arriving, so the
    // output stays blocked and the input stalls behind it.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    random_traffic(PRESSURE_ITEMS, 1'b1);
    task_in.valid <= 1'b0;

    // Drain: wait for every expected result, then a few more cycles to catch
    // any stray result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions in, %0d results checked, peak occupancy %0d",
             items_accepted, results_checked, peak_occupancy);
    $display("outcomes: inserted %0d, popped %0d, pop on empty %0d, insert on full %0d",
             outcome_seen[OUT_INSERTED], outcome_seen[OUT_POPPED],
             outcome_seen[OUT_EMPTY], outcome_seen[OUT_FULL]);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
